### rtl/core/pfmp_pkg.sv
package pfmp_pkg;

    localparam int DATA_STORE_SIZE  = 1024;
    localparam int PREFIX_BYTES     = 6;
    localparam int FIELD_TEXT_LIMIT = 16;

    localparam int PREFIX_W = 8 * PREFIX_BYTES;
    localparam int OP_W     = 10;
    localparam int LEN_W    = 16;
    localparam int CNT_W    = $clog2(DATA_STORE_SIZE + 1);
    localparam int POS_W    = $clog2(((FIELD_TEXT_LIMIT > PREFIX_BYTES) ?
                                       FIELD_TEXT_LIMIT : PREFIX_BYTES) + 1);
    localparam int CFG_W    = (PREFIX_W > OP_W) ? PREFIX_W : OP_W;
    localparam int IDX_W    = 2;

    localparam logic [7:0] SEP_CHAR = 8'h7C;

    localparam logic [PREFIX_W-1:0] PREFIX_RESET = PREFIX_W'(48'd75133289350992);
    localparam logic [OP_W-1:0]     OPLO_RESET   = OP_W'(1);
    localparam logic [OP_W-1:0]     OPHI_RESET   = OP_W'(99);
    localparam logic [OP_W-1:0]     OPEX_RESET   = OP_W'(500);

    localparam logic [IDX_W-1:0] CFG_PREFIX_WORD  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_OPCODE_LOW   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_OPCODE_HIGH  = 2'd2;
    localparam logic [IDX_W-1:0] CFG_OPCODE_EXTRA = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_PREFIX = 3'd1;
    localparam logic [2:0] ST_BAD_FORMAT = 3'd2;
    localparam logic [2:0] ST_BAD_OPCODE = 3'd3;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd4;
    localparam logic [2:0] ST_OVERFLOW   = 3'd5;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       end_of_message;
    } msg_t;

    typedef struct packed {
        logic             payload_valid;
        logic [7:0]       payload_byte;
        logic             verdict_valid;
        logic [OP_W-1:0]  op_value;
        logic [LEN_W-1:0] length_value;
        logic [CNT_W-1:0] payload_count;
        logic [2:0]       status;
    } res_t;

    typedef struct packed {
        logic [PREFIX_W-1:0] prefix_word;
        logic [OP_W-1:0]     opcode_low;
        logic [OP_W-1:0]     opcode_high;
        logic [OP_W-1:0]     opcode_extra;
    } cfg_t;

endpackage

### rtl/core/pipe_framed_message_parser_unit.sv
// channel  | handshake                   | payload
// msg      | msg_valid / msg_stall       | msg_t: msg_byte, end_of_message
// res      | res_valid / res_stall       | res_t: payload and verdict fields
// cfg      | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// One byte per cycle while res is not stalled.
// A result passes the input register and then the result register, parse logic between.
// Bytes that give no result still pass at one per cycle when res is stalled.
// rst_n clears parse state and loads register defaults; cfg_ready stays high.
module pipe_framed_message_parser_unit
    import pfmp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             msg_valid,
    output logic             msg_stall,
    input  msg_t             msg,
    output logic             res_valid,
    input  logic             res_stall,
    output res_t             res,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    cfg_t cfg;
    logic res_free;
    logic res_load;
    res_t res_next;

    pfmp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pfmp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg       (msg),
        .cfg       (cfg),
        .res_free  (res_free),
        .res_load  (res_load),
        .res_next  (res_next)
    );

    pfmp_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_load  (res_load),
        .res_next  (res_next),
        .res_free  (res_free),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

### rtl/core/pfmp_cfg.sv
module pfmp_cfg
    import pfmp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prefix_word  <= PREFIX_RESET;
            cfg_reg.opcode_low   <= OPLO_RESET;
            cfg_reg.opcode_high  <= OPHI_RESET;
            cfg_reg.opcode_extra <= OPEX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PREFIX_WORD:  cfg_reg.prefix_word  <= cfg_data[PREFIX_W-1:0];
                CFG_OPCODE_LOW:   cfg_reg.opcode_low   <= cfg_data[OP_W-1:0];
                CFG_OPCODE_HIGH:  cfg_reg.opcode_high  <= cfg_data[OP_W-1:0];
                CFG_OPCODE_EXTRA: cfg_reg.opcode_extra <= cfg_data[OP_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

### rtl/core/pfmp_parse.sv
module pfmp_parse
    import pfmp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic msg_valid,
    output logic msg_stall,
    input  msg_t msg,
    input  cfg_t cfg,
    input  logic res_free,
    output logic res_load,
    output res_t res_next
);

    localparam logic [2:0] PH_PREFIX = 3'd0;
    localparam logic [2:0] PH_SEP    = 3'd1;
    localparam logic [2:0] PH_OP     = 3'd2;
    localparam logic [2:0] PH_LEN    = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    localparam logic [OP_W-1:0]  OP_MAX  = '1;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(DATA_STORE_SIZE);
    localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(DATA_STORE_SIZE - 1);
    localparam logic [POS_W-1:0] POS_LIM = POS_W'(FIELD_TEXT_LIMIT);
    localparam logic [POS_W-1:0] POS_PFX = POS_W'(PREFIX_BYTES);

    function automatic logic [2:0] fin_code(input logic [2:0] ph, input logic [CNT_W-1:0] cnt);
        logic [2:0] code;
        code = ST_OK;
        unique case (ph)
            PH_PREFIX:              code = ST_BAD_PREFIX;
            PH_SEP, PH_OP, PH_LEN:  code = ST_BAD_FORMAT;
            PH_DATA:                code = (cnt > CNT_LIM) ? ST_OVERFLOW : ST_OK;
            default:                code = ST_OK;
        endcase
        return code;
    endfunction

    logic             in_vld_reg;
    msg_t             in_reg;
    logic             advance;
    logic             produce;

    logic [2:0]       phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [OP_W-1:0]  op_reg, op_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             nd_reg, nd_next;
    logic [2:0]       err_reg, err_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [7:0]       b;
    logic             last;
    logic             data;
    logic             is_digit;
    logic [3:0]       digit;
    logic [7:0]       want;
    logic [POS_W-1:0] pos_inc;
    logic [OP_W+3:0]  op_mul;
    logic [LEN_W+3:0] len_mul;
    logic [OP_W-1:0]  op_sat;
    logic [LEN_W-1:0] len_sat;
    logic             op_ok;

    assign b        = in_reg.msg_byte;
    assign last     = in_reg.end_of_message;
    assign is_digit = (b >= 8'h30) && (b <= 8'h39);
    assign digit    = b[3:0];
    assign pos_inc  = (pos_reg < POS_LIM) ? pos_reg + 1'b1 : pos_reg;

    assign op_mul  = ({4'b0, op_reg} << 3) + ({4'b0, op_reg} << 1) + (OP_W + 4)'(digit);
    assign len_mul = ({4'b0, len_reg} << 3) + ({4'b0, len_reg} << 1) + (LEN_W + 4)'(digit);
    assign op_sat  = (op_mul > (OP_W + 4)'(OP_MAX)) ? OP_MAX : op_mul[OP_W-1:0];
    assign len_sat = (len_mul > (LEN_W + 4)'(LEN_MAX)) ? LEN_MAX : len_mul[LEN_W-1:0];
    assign op_ok   = ((op_reg >= cfg.opcode_low) && (op_reg <= cfg.opcode_high))
                     || (op_reg == cfg.opcode_extra);

    // expected prefix byte, first byte in the top lane
    always_comb
    begin
        want = 8'h00;
        for (int i = 0; i < PREFIX_BYTES; i++)
        begin
            if (pos_reg == POS_W'(PREFIX_BYTES - 1 - i))
                want = cfg.prefix_word[8*i +: 8];
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        op_next    = op_reg;
        len_next   = len_reg;
        nd_next    = nd_reg;
        err_next   = err_reg;
        cnt_next   = cnt_reg;
        data       = 1'b0;
        if (phase_reg != PH_DONE)
        begin
            if (b == 8'h00)
            begin
                phase_next = PH_DONE;
                err_next   = fin_code(phase_reg, cnt_reg);
            end
            else
            begin
                unique case (phase_reg)
                    PH_PREFIX:
                    begin
                        if (b != want)
                        begin
                            phase_next = PH_DONE;
                            err_next   = ST_BAD_PREFIX;
                        end
                        else if (pos_reg + 1'b1 >= POS_PFX)
                        begin
                            phase_next = PH_SEP;
                            pos_next   = '0;
                        end
                        else
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                    PH_SEP:
                    begin
                        if (b == SEP_CHAR)
                            phase_next = PH_OP;
                        else
                        begin
                            phase_next = PH_DONE;
                            err_next   = ST_BAD_FORMAT;
                        end
                    end
                    PH_OP:
                    begin
                        if (b == SEP_CHAR)
                        begin
                            if (pos_reg == '0 || pos_reg >= POS_LIM)
                            begin
                                phase_next = PH_DONE;
                                err_next   = ST_BAD_FORMAT;
                            end
                            else if (nd_reg || !op_ok)
                            begin
                                phase_next = PH_DONE;
                                err_next   = ST_BAD_OPCODE;
                            end
                            else
                            begin
                                phase_next = PH_LEN;
                                pos_next   = '0;
                                nd_next    = 1'b0;
                            end
                        end
                        else
                        begin
                            pos_next = pos_inc;
                            if (is_digit)
                                op_next = op_sat;
                            else
                                nd_next = 1'b1;
                        end
                    end
                    PH_LEN:
                    begin
                        if (b == SEP_CHAR)
                        begin
                            if (pos_reg == '0 || pos_reg >= POS_LIM || nd_reg
                                || len_reg > LEN_W'(DATA_STORE_SIZE - 1))
                            begin
                                phase_next = PH_DONE;
                                err_next   = ST_BAD_LENGTH;
                            end
                            else
                                phase_next = PH_DATA;
                        end
                        else
                        begin
                            pos_next = pos_inc;
                            if (is_digit)
                                len_next = len_sat;
                            else
                                nd_next = 1'b1;
                        end
                    end
                    PH_DATA:
                    begin
                        data = 1'b1;
                        if (cnt_reg < CNT_TOP)
                            cnt_next = cnt_reg + 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        res_next               = '0;
        res_next.payload_valid = data;
        res_next.payload_byte  = data ? b : 8'h00;
        res_next.verdict_valid = last;
        if (last)
        begin
            res_next.op_value      = op_next;
            res_next.length_value  = len_next;
            res_next.payload_count = cnt_next;
            res_next.status        = (phase_next == PH_DONE) ? err_next
                                                             : fin_code(phase_next, cnt_next);
        end
    end

    assign produce   = data || last;
    assign advance   = in_vld_reg && (!produce || res_free);
    assign res_load  = advance && produce;
    assign msg_stall = in_vld_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (msg_valid && !msg_stall)
            in_vld_reg <= 1'b1;
        else if (advance)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (msg_valid && !msg_stall)
            in_reg <= msg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREFIX;
            pos_reg   <= '0;
            op_reg    <= '0;
            len_reg   <= '0;
            nd_reg    <= 1'b0;
            err_reg   <= ST_OK;
            cnt_reg   <= '0;
        end
        else if (advance)
        begin
            if (last)
            begin
                phase_reg <= PH_PREFIX;
                pos_reg   <= '0;
                op_reg    <= '0;
                len_reg   <= '0;
                nd_reg    <= 1'b0;
                err_reg   <= ST_OK;
                cnt_reg   <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                op_reg    <= op_next;
                len_reg   <= len_next;
                nd_reg    <= nd_next;
                err_reg   <= err_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

    a_verdict_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_load && res_next.verdict_valid |=> phase_reg == PH_PREFIX && cnt_reg == '0)
        else $error("state not cleared after verdict");

    a_count_only_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PREFIX || phase_reg == PH_SEP || phase_reg == PH_OP
         || phase_reg == PH_LEN) |-> cnt_reg == '0)
        else $error("data count moved outside data phase");

    a_error_ends_parse: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != ST_OK |-> phase_reg == PH_DONE)
        else $error("error recorded while still parsing");

endmodule

### rtl/core/pfmp_obuf.sv
module pfmp_obuf
    import pfmp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic res_load,
    input  res_t res_next,
    output logic res_free,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    logic out_vld_reg;
    res_t out_reg;

    assign res_free  = !out_vld_reg || !res_stall;
    assign res_valid = out_vld_reg;
    assign res       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (res_load)
            out_vld_reg <= 1'b1;
        else if (!res_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            out_reg <= res_next;
    end

endmodule
